### rtl/prd_pkg.sv
// Shared constants and pipeline stage types of the pinhole ray direction block
`timescale 1ns / 1ps
package prd_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int PIX_W     = 12;
	localparam int DIM_W     = 13;
	localparam int DIR_W     = 32;
	localparam int MAG_W     = 30;
	localparam int SQ_W      = 63;
	localparam int ROOT_W    = 31;
	localparam int REM_W     = 62;
	localparam int QUO_W     = 31;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 31;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

	typedef struct packed {
		logic                   vld;
		logic [SQ_W-1:0]        rem;
		logic [SQ_W-1:0]        root;
		logic [2:0][MAG_W-1:0]  mag;
		logic [2:0]             neg;
		logic                   oor;
	} sqrt_stage_t;

	typedef struct packed {
		logic                   vld;
		logic [ROOT_W-1:0]      norm;
		logic [2:0][REM_W-1:0]  rem;
		logic [2:0][QUO_W-1:0]  quo;
		logic [2:0]             neg;
		logic                   oor;
	} div_stage_t;

endpackage

### rtl/prd_if.sv
// Pixel and ray channel interfaces of the pinhole ray direction block
`timescale 1ns / 1ps
interface prd_pix_if;
	logic                      valid;
	logic                      ready;
	logic [prd_pkg::PIX_W-1:0] pixel_x;
	logic [prd_pkg::PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface prd_ray_if;
	logic                             valid;
	logic                             ready;
	logic signed [prd_pkg::DIR_W-1:0] dir_x;
	logic signed [prd_pkg::DIR_W-1:0] dir_y;
	logic signed [prd_pkg::DIR_W-1:0] dir_z;
	logic                             out_of_range;

	modport source (output valid, output dir_x, output dir_y, output dir_z,
		output out_of_range, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z,
		input out_of_range, output ready);
endinterface

### rtl/pinhole_ray_direction_top.sv
// Pinhole camera primary ray direction pipeline, top level
//
// Takes one pixel coordinate per clock and returns the unit direction of the ray through the
// pixel centre in signed Q1.30, with a flag for coordinates outside the image. The pipeline
// has nine stages for plane point, rotation and scaling, 32 for the bit-per-stage square
// root and 32 for the three bit-per-stage dividers, then the output register. The pipeline
// moves as a whole; it holds while a finished ray is not taken. Write configuration only
// while no pixel is in flight.
`timescale 1ns / 1ps
module pinhole_ray_direction_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [prd_pkg::CFG_W-1:0]       cfg_data,
	prd_pix_if.sink                         pix,
	prd_ray_if.source                       ray
);
	import prd_pkg::*;

	function automatic logic signed [31:0] plane_sat(input logic [45:0] t);
		logic [44:0] q;
		q = t[45:1];
		if (q[44:31] != {14{q[44]}})
			return q[44] ? 32'sh80000000 : 32'sh7fffffff;
		return $signed(q[31:0]);
	endfunction

	function automatic logic signed [47:0] mul_kw(input logic [15:0] k, input logic [31:0] w);
		logic signed [47:0] a;
		logic signed [47:0] b;
		a = $signed({{32{k[15]}}, k});
		b = $signed({{16{w[31]}}, w});
		return a * b;
	endfunction

	logic [CFG_W-1:0]  row_q [3];
	logic [31:0]       half_w_q;
	logic [31:0]       half_h_q;
	logic [30:0]       pitch_q;
	logic [DIM_W-1:0]  img_w_q;
	logic [DIM_W-1:0]  img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 48'h1000_0000_0000;
			row_q[1] <= 48'h0000_1000_0000;
			row_q[2] <= 48'h0000_0000_1000;
			half_w_q <= '0;
			half_h_q <= '0;
			pitch_q  <= '0;
			img_w_q  <= DIM_W'(1);
			img_h_q  <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROW_X:        row_q[0] <= cfg_data;
				REG_ROW_Y:        row_q[1] <= cfg_data;
				REG_ROW_Z:        row_q[2] <= cfg_data;
				REG_HALF_WIDTH:   half_w_q <= cfg_data[31:0];
				REG_HALF_HEIGHT:  half_h_q <= cfg_data[31:0];
				REG_PIXEL_PITCH:  pitch_q  <= cfg_data[30:0];
				REG_IMAGE_WIDTH:  img_w_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: img_h_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || ray.ready;
	assign pix.ready = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7, oor_s8, oor_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	logic [43:0]        off_x_s1, off_y_s1;
	logic signed [31:0] wx_s2, wy_s2;
	logic signed [47:0] p_s3 [3][2];
	logic [49:0]        v_s4 [3];
	logic [47:0]        mag_s5 [3];
	logic [2:0]         neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [47:0]        mag_s6 [3];
	logic [47:0]        mag_s7 [3];
	logic [47:0]        max_s6;
	logic [4:0]         sh_s7;
	logic [MAG_W-1:0]   mag_s8 [3];
	logic [MAG_W-1:0]   mag_s9 [3];
	logic [59:0]        sqr_s9 [3];
	logic [4:0]         sh_c;

	always_comb begin
		sh_c = '0;
		for (int i = 30; i < 48; i++)
			if (max_s6[i])
				sh_c = 5'(i - 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_x_s1 <= 44'({pix.pixel_x, 1'b1} * pitch_q);
			off_y_s1 <= 44'({pix.pixel_y, 1'b1} * pitch_q);
			oor_s1   <= ({1'b0, pix.pixel_x} >= img_w_q) || ({1'b0, pix.pixel_y} >= img_h_q) ||
				(32'(pix.pixel_x) >= MAX_DIM) || (32'(pix.pixel_y) >= MAX_DIM);

			wx_s2  <= plane_sat({{13{half_w_q[31]}}, half_w_q, 1'b0} - {2'b00, off_x_s1} + 46'd1);
			wy_s2  <= plane_sat({{13{half_h_q[31]}}, half_h_q, 1'b0} - {2'b00, off_y_s1} + 46'd1);
			oor_s2 <= oor_s1;

			for (int r = 0; r < 3; r++) begin
				p_s3[r][0] <= mul_kw(row_q[r][47:32], wx_s2);
				p_s3[r][1] <= mul_kw(row_q[r][31:16], wy_s2);
			end
			oor_s3 <= oor_s2;

			for (int r = 0; r < 3; r++)
				v_s4[r] <= {{2{p_s3[r][0][47]}}, p_s3[r][0]} + {{2{p_s3[r][1][47]}}, p_s3[r][1]}
					- {{10{row_q[r][15]}}, row_q[r][15:0], 24'd0};
			oor_s4 <= oor_s3;

			for (int r = 0; r < 3; r++) begin
				neg_s5[r] <= v_s4[r][49];
				mag_s5[r] <= v_s4[r][49] ? 48'(-v_s4[r]) : v_s4[r][47:0];
			end
			oor_s5 <= oor_s4;

			max_s6 <= (mag_s5[0] >= mag_s5[1]) ?
				((mag_s5[0] >= mag_s5[2]) ? mag_s5[0] : mag_s5[2]) :
				((mag_s5[1] >= mag_s5[2]) ? mag_s5[1] : mag_s5[2]);
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			oor_s6 <= oor_s5;

			sh_s7  <= sh_c;
			mag_s7 <= mag_s6;
			neg_s7 <= neg_s6;
			oor_s7 <= oor_s6;

			for (int r = 0; r < 3; r++)
				mag_s8[r] <= MAG_W'(mag_s7[r] >> sh_s7);
			neg_s8 <= neg_s7;
			oor_s8 <= oor_s7;

			for (int r = 0; r < 3; r++)
				sqr_s9[r] <= 60'(mag_s8[r] * mag_s8[r]);
			mag_s9 <= mag_s8;
			neg_s9 <= neg_s8;
			oor_s9 <= oor_s8;
		end
	end

	sqrt_stage_t sq_s [SQRT_STEPS+1];
	div_stage_t  dv_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_s[0] <= '0;
		end else if (en) begin
			sq_s[0].vld  <= vld_s9;
			sq_s[0].rem  <= {3'b000, sqr_s9[0]} + {3'b000, sqr_s9[1]} + {3'b000, sqr_s9[2]};
			sq_s[0].root <= '0;
			for (int r = 0; r < 3; r++)
				sq_s[0].mag[r] <= mag_s9[r];
			sq_s[0].neg  <= neg_s9;
			sq_s[0].oor  <= oor_s9;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = sq_s[k].root + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_s[k+1] <= '0;
			end else if (en) begin
				sq_s[k+1] <= sq_s[k];
				if (sq_s[k].rem >= trial) begin
					sq_s[k+1].rem  <= sq_s[k].rem - trial;
					sq_s[k+1].root <= (sq_s[k].root >> 1) + BIT;
				end else begin
					sq_s[k+1].root <= sq_s[k].root >> 1;
				end
			end
		end
	end

	logic [ROOT_W-1:0] norm_c;
	assign norm_c = sq_s[SQRT_STEPS].root[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= '0;
		end else if (en) begin
			dv_s[0].vld  <= sq_s[SQRT_STEPS].vld;
			dv_s[0].norm <= norm_c;
			for (int r = 0; r < 3; r++)
				dv_s[0].rem[r] <= ({32'd0, sq_s[SQRT_STEPS].mag[r]} << 30)
					+ {32'd0, norm_c[ROOT_W-1:1]};
			dv_s[0].quo  <= '0;
			dv_s[0].neg  <= sq_s[SQRT_STEPS].neg;
			dv_s[0].oor  <= sq_s[SQRT_STEPS].oor;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int QB = DIV_STEPS - 1 - j;
		logic [REM_W-1:0] sub;
		assign sub = REM_W'(dv_s[j].norm) << QB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= '0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
				for (int r = 0; r < 3; r++)
					if (dv_s[j].rem[r] >= sub) begin
						dv_s[j+1].rem[r]     <= dv_s[j].rem[r] - sub;
						dv_s[j+1].quo[r][QB] <= 1'b1;
					end
			end
		end
	end

	logic [QUO_W-1:0]   dmag_c [3];
	logic [DIR_W-1:0]   dir_c  [3];
	logic [DIR_W-1:0]   dir_q  [3];
	logic               oor_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (dv_s[DIV_STEPS].norm == '0)
				dmag_c[r] = '0;
			else if (dv_s[DIV_STEPS].quo[r] > (QUO_W'(1) << 30))
				dmag_c[r] = QUO_W'(1) << 30;
			else
				dmag_c[r] = dv_s[DIV_STEPS].quo[r];
			dir_c[r] = dv_s[DIV_STEPS].neg[r] ? -{1'b0, dmag_c[r]} : {1'b0, dmag_c[r]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= dv_s[DIV_STEPS].vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_q <= dir_c;
			oor_q <= dv_s[DIV_STEPS].oor;
		end
	end

	assign ray.valid        = out_vld_q;
	assign ray.dir_x        = $signed(dir_q[0]);
	assign ray.dir_y        = $signed(dir_q[1]);
	assign ray.dir_z        = $signed(dir_q[2]);
	assign ray.out_of_range = oor_q;

endmodule
